// ----- rtl/cth_pkg.sv -----
`default_nettype none
// ============================================================================
// cth_pkg
// Shared types, constants and decode functions of the codon translator.
// ============================================================================
package cth_pkg;

    // Counter defaults and table sizes
    localparam int CTH_COUNT_WIDTH = 32;
    localparam int NUM_AMINO       = 20;
    localparam int AMINO_AW        = $clog2(NUM_AMINO);
    localparam int OUT_WIDTH       = 32;

    // Request kinds
    localparam logic KIND_BASE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Nucleotide codes
    localparam logic [1:0] BASE_T = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_A = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    // Amino acid counter indexes, alphabetical by letter
    localparam logic [4:0] AA_A = 5'd0;
    localparam logic [4:0] AA_C = 5'd1;
    localparam logic [4:0] AA_D = 5'd2;
    localparam logic [4:0] AA_E = 5'd3;
    localparam logic [4:0] AA_F = 5'd4;
    localparam logic [4:0] AA_G = 5'd5;
    localparam logic [4:0] AA_H = 5'd6;
    localparam logic [4:0] AA_I = 5'd7;
    localparam logic [4:0] AA_K = 5'd8;
    localparam logic [4:0] AA_L = 5'd9;
    localparam logic [4:0] AA_M = 5'd10;
    localparam logic [4:0] AA_N = 5'd11;
    localparam logic [4:0] AA_P = 5'd12;
    localparam logic [4:0] AA_Q = 5'd13;
    localparam logic [4:0] AA_R = 5'd14;
    localparam logic [4:0] AA_S = 5'd15;
    localparam logic [4:0] AA_T = 5'd16;
    localparam logic [4:0] AA_V = 5'd17;
    localparam logic [4:0] AA_W = 5'd18;
    localparam logic [4:0] AA_Y = 5'd19;
    localparam logic [4:0] AA_STOP = 5'd31;

    // Reading frame phase
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SEEN_A,
        PH_SEEN_AT,
        PH_CODON,
        PH_BASE1,
        PH_BASE2
    } cth_phase_t;

    // Request payload
    typedef struct packed {
        logic       kind;
        logic [7:0] base_char;
        logic [4:0] read_index;
    } cth_in_t;

    // Result payload
    typedef struct packed {
        logic        emitted;
        logic [4:0]  amino_index;
        logic [6:0]  amino_letter;
        logic        stop_codon;
        logic        in_frame;
        logic [31:0] count_value;
        logic [31:0] total_value;
    } cth_out_t;

    // ASCII byte to nucleotide code; anything unknown is G
    function automatic logic [1:0] base_code(input logic [7:0] ch);
        logic [1:0] code;
        case (ch)
            8'h54:   code = BASE_T;   // 'T'
            8'h43:   code = BASE_C;   // 'C'
            8'h41:   code = BASE_A;   // 'A'
            default: code = BASE_G;
        endcase
        return code;
    endfunction

    // Standard genetic code, codon = {b1, b2, b3}; AA_STOP for stop codons
    function automatic logic [4:0] codon_amino(input logic [5:0] codon);
        logic [4:0] aa;
        case (codon) inside
            [6'd0:6'd1]:               aa = AA_F;
            [6'd2:6'd3]:               aa = AA_L;
            [6'd4:6'd7]:               aa = AA_S;
            [6'd8:6'd9]:               aa = AA_Y;
            6'd10, 6'd11, 6'd14:       aa = AA_STOP;
            [6'd12:6'd13]:             aa = AA_C;
            6'd15:                     aa = AA_W;
            [6'd16:6'd19]:             aa = AA_L;
            [6'd20:6'd23]:             aa = AA_P;
            [6'd24:6'd25]:             aa = AA_H;
            [6'd26:6'd27]:             aa = AA_Q;
            [6'd28:6'd31]:             aa = AA_R;
            [6'd32:6'd34]:             aa = AA_I;
            6'd35:                     aa = AA_M;
            [6'd36:6'd39]:             aa = AA_T;
            [6'd40:6'd41]:             aa = AA_N;
            [6'd42:6'd43]:             aa = AA_K;
            [6'd44:6'd45]:             aa = AA_S;
            [6'd46:6'd47]:             aa = AA_R;
            [6'd48:6'd51]:             aa = AA_V;
            [6'd52:6'd55]:             aa = AA_A;
            [6'd56:6'd57]:             aa = AA_D;
            [6'd58:6'd59]:             aa = AA_E;
            default:                   aa = AA_G;
        endcase
        return aa;
    endfunction

    // Counter index to one-letter ASCII code; 0 outside the table
    function automatic logic [6:0] amino_letter(input logic [4:0] idx);
        logic [6:0] l;
        unique case (idx)
            AA_A:    l = 7'h41;
            AA_C:    l = 7'h43;
            AA_D:    l = 7'h44;
            AA_E:    l = 7'h45;
            AA_F:    l = 7'h46;
            AA_G:    l = 7'h47;
            AA_H:    l = 7'h48;
            AA_I:    l = 7'h49;
            AA_K:    l = 7'h4B;
            AA_L:    l = 7'h4C;
            AA_M:    l = 7'h4D;
            AA_N:    l = 7'h4E;
            AA_P:    l = 7'h50;
            AA_Q:    l = 7'h51;
            AA_R:    l = 7'h52;
            AA_S:    l = 7'h53;
            AA_T:    l = 7'h54;
            AA_V:    l = 7'h56;
            AA_W:    l = 7'h57;
            AA_Y:    l = 7'h59;
            default: l = 7'h00;
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cth_ram.sv -----
`default_nettype none
// ============================================================================
// cth_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read (old data on same-address write)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/cth_outq.sv -----
`default_nettype none
// ============================================================================
// cth_outq
// Two-entry result queue that decouples the counter pipeline from the sink.
// ============================================================================
module cth_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cth_pkg::cth_out_t push_data,
    output logic [1:0]             level,
    output logic                   pop,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output cth_pkg::cth_out_t      res_data
);
    import cth_pkg::*;

    cth_out_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Handshake and pointer update
    always_comb
    begin
        res_valid   = (count_reg != 2'd0);
        res_data    = slot_reg[rd_ptr_reg];
        pop         = res_valid && res_ready;
        level       = count_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/codon_translator_histogram.sv -----
`default_nettype none
// ============================================================================
// codon_translator_histogram
// Finds ATG in a nucleotide stream, translates codons in frame and keeps
// saturating per-amino-acid and total counters; read requests return one.
// ============================================================================
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+------------------
//  nuc     | nuc_valid / nuc_ready / nuc_data | in      | cth_in_t
//  res     | res_valid / res_ready / res_data | out     | cth_out_t
//
// One request per cycle while nuc_ready is high; results pass stage 1, then the queue.
// Stage 0 runs the frame FSM and the total counter and issues the counter
// RAM read; stage 1 increments and writes back, forwarding the last write.
// Reset clears the FSM, the total and a valid bit per counter entry, so the
// block takes requests straight after reset.
// A two-entry result queue absorbs sink stalls; nuc_ready drops only when it
// and the pipeline stage hold two results not being taken.
//
module codon_translator_histogram #(
    parameter int COUNT_WIDTH = cth_pkg::CTH_COUNT_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              nuc_valid,
    output logic                   nuc_ready,
    input  wire cth_pkg::cth_in_t  nuc_data,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output cth_pkg::cth_out_t      res_data
);
    import cth_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Stage 0 state
    cth_phase_t              phase_reg, phase_next;
    logic [3:0]              bases_reg, bases_next;
    logic [COUNT_WIDTH-1:0]  total_reg, total_next;

    // Stage 1 registers
    logic                    s1_valid_reg;
    logic                    s1_hit_reg;
    logic                    s1_show_reg;
    logic                    s1_stop_reg;
    logic                    s1_frame_reg;
    logic [4:0]              s1_idx_reg;
    logic [AMINO_AW-1:0]     s1_addr_reg;
    logic [COUNT_WIDTH-1:0]  s1_total_reg;

    // Counter entry valid bits and last-write forwarding
    logic [NUM_AMINO-1:0]    cnt_valid_reg;
    logic                    wl_valid_reg;
    logic [AMINO_AW-1:0]     wl_addr_reg;
    logic [COUNT_WIDTH-1:0]  wl_data_reg;

    // Stage 0 combinational
    logic                    accept;
    logic                    is_base;
    logic [1:0]              b;
    logic [4:0]              codon_aa;
    logic                    hit;
    logic                    stop;
    logic [4:0]              hit_idx;
    logic                    read_ok;
    logic [4:0]              s0_idx;
    logic [AMINO_AW-1:0]     rd_addr;
    logic                    frame_after;

    // Stage 1 combinational
    logic [COUNT_WIDTH-1:0]  ram_rdata;
    logic [COUNT_WIDTH-1:0]  cur_cnt;
    logic [COUNT_WIDTH-1:0]  inc_cnt;
    logic [COUNT_WIDTH-1:0]  shown_cnt;
    logic [63:0]             cnt_wide;
    logic [63:0]             total_wide;
    logic                    wr_en;
    cth_out_t                s1_result;

    // Queue status
    logic [1:0]              q_level;
    logic                    q_pop;
    logic [2:0]              occupancy;

    // Flow control: accept when queue plus stage 1 leave a free place
    always_comb
    begin
        occupancy = {1'b0, q_level} + {2'b00, s1_valid_reg};
        nuc_ready = (occupancy <= ({2'b00, q_pop} + 3'd1));
        accept    = nuc_valid && nuc_ready;
        is_base   = (nuc_data.kind == KIND_BASE);
    end

    // Frame FSM next state and codon decode
    always_comb
    begin
        b          = base_code(nuc_data.base_char);
        codon_aa   = codon_amino({bases_reg, b});
        phase_next = phase_reg;
        bases_next = bases_reg;
        hit        = 1'b0;
        stop       = 1'b0;
        hit_idx    = AA_A;
        unique case (phase_reg)
            PH_SEARCH, PH_SEEN_A, PH_SEEN_AT:
            begin
                if (b == BASE_A)
                begin
                    phase_next = PH_SEEN_A;
                end
                else if (phase_reg == PH_SEEN_A && b == BASE_T)
                begin
                    phase_next = PH_SEEN_AT;
                end
                else if (phase_reg == PH_SEEN_AT && b == BASE_G)
                begin
                    hit        = 1'b1;
                    hit_idx    = AA_M;
                    phase_next = PH_CODON;
                end
                else
                begin
                    phase_next = PH_SEARCH;
                end
            end
            PH_CODON:
            begin
                bases_next = {b, 2'b00};
                phase_next = PH_BASE1;
            end
            PH_BASE1:
            begin
                bases_next = {bases_reg[3:2], b};
                phase_next = PH_BASE2;
            end
            PH_BASE2:
            begin
                if (codon_aa == AA_STOP)
                begin
                    stop       = 1'b1;
                    phase_next = PH_SEARCH;
                end
                else
                begin
                    hit        = 1'b1;
                    hit_idx    = codon_aa;
                    phase_next = PH_CODON;
                end
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase

        // Total counter bump on every counted amino acid
        total_next = total_reg;
        if (hit && total_reg != CNT_MAX)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    // Counter address and result fields decided in stage 0
    always_comb
    begin
        read_ok = (nuc_data.read_index < 5'(NUM_AMINO));
        if (is_base)
        begin
            s0_idx      = hit ? hit_idx : AA_A;
            rd_addr     = AMINO_AW'(hit_idx);
            frame_after = (phase_next == PH_CODON) || (phase_next == PH_BASE1)
                          || (phase_next == PH_BASE2);
        end
        else
        begin
            s0_idx      = nuc_data.read_index;
            rd_addr     = read_ok ? AMINO_AW'(nuc_data.read_index) : '0;
            frame_after = (phase_reg == PH_CODON) || (phase_reg == PH_BASE1)
                          || (phase_reg == PH_BASE2);
        end
    end

    // Frame and total registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            bases_reg <= 4'd0;
            total_reg <= '0;
        end
        else if (accept && is_base)
        begin
            phase_reg <= phase_next;
            bases_reg <= bases_next;
            total_reg <= total_next;
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg   <= is_base && hit;
            s1_show_reg  <= is_base ? hit : read_ok;
            s1_stop_reg  <= is_base && stop;
            s1_frame_reg <= frame_after;
            s1_idx_reg   <= s0_idx;
            s1_addr_reg  <= rd_addr;
            s1_total_reg <= is_base ? total_next : total_reg;
        end
    end

    // Counter memory
    cth_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_AMINO)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (inc_cnt),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Read-modify-write with forwarding of the previous write
    always_comb
    begin
        if (wl_valid_reg && wl_addr_reg == s1_addr_reg)
        begin
            cur_cnt = wl_data_reg;
        end
        else if (cnt_valid_reg[s1_addr_reg])
        begin
            cur_cnt = ram_rdata;
        end
        else
        begin
            cur_cnt = '0;
        end
        inc_cnt   = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + 1'b1;
        wr_en     = s1_valid_reg && s1_hit_reg;
        if (s1_hit_reg)
        begin
            shown_cnt = inc_cnt;
        end
        else if (s1_show_reg)
        begin
            shown_cnt = cur_cnt;
        end
        else
        begin
            shown_cnt = '0;
        end
        cnt_wide   = 64'(shown_cnt);
        total_wide = 64'(s1_total_reg);

        s1_result.emitted      = s1_hit_reg;
        s1_result.amino_index  = s1_idx_reg;
        s1_result.amino_letter = s1_show_reg ? amino_letter(s1_idx_reg) : 7'd0;
        s1_result.stop_codon   = s1_stop_reg;
        s1_result.in_frame     = s1_frame_reg;
        s1_result.count_value  = cnt_wide[OUT_WIDTH-1:0];
        s1_result.total_value  = total_wide[OUT_WIDTH-1:0];
    end

    // Entry valid bits and last-write tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            wl_valid_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            cnt_valid_reg[s1_addr_reg] <= 1'b1;
            wl_valid_reg               <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wl_addr_reg <= s1_addr_reg;
            wl_data_reg <= inc_cnt;
        end
    end

    // Result queue
    cth_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .level     (q_level),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire

// ----- bench/codon_translator_histogram_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// codon_translator_histogram_tb
// Drives nucleotide and counter-read requests into the codon translator and
// checks every result against a local model of the reading frame, codon
// table and saturating counters, or a hand-written result on fixed rows.
// A short directed table comes first, then random genes (ATG, random codons,
// mostly a stop) with noise, under several sender and receiver idling patterns.
// ============================================================================
module codon_translator_histogram_tb;
    import cth_pkg::*;

    // Frame codes of the local model: 4..7 one base seen, 8..23 two bases seen
    localparam int FR_SEARCH  = 0;
    localparam int FR_SEEN_A  = 1;
    localparam int FR_SEEN_AT = 2;
    localparam int FR_CODON   = 3;

    localparam int PHASE_ITEMS = 135;
    localparam int WATCHDOG    = 2000;
    localparam int TAIL_CYCLES = 10;

    // One row of stimulus; fixed rows carry a hand-written expected result
    typedef struct {
        cth_in_t  req;
        bit       fixed;
        cth_out_t res;
    } stim_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      nuc_valid = 1'b0;
    logic      nuc_ready;
    cth_in_t   nuc_data  = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    cth_out_t  res_data;

    // Model state
    int          frame_code;
    logic [31:0] amino_count [NUM_AMINO];
    logic [31:0] total_count;

    string amino_alpha   = "ACDEFGHIKLMNPQRSTVWY";
    // Indexed by 16*b1 + 4*b2 + b3 with T=0 C=1 A=2 G=3; '*' marks a stop
    string codon_letters = "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

    stim_row_t stim_q[$];
    cth_out_t  translation_q[$];
    stim_row_t in_flight;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        fail_count     = 0;

    codon_translator_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .nuc_valid (nuc_valid),
        .nuc_ready (nuc_ready),
        .nuc_data  (nuc_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------
    function automatic logic [1:0] nucleotide_code(logic [7:0] ch);
        if (ch == "T") return BASE_T;
        if (ch == "C") return BASE_C;
        if (ch == "A") return BASE_A;
        return BASE_G;
    endfunction

    function automatic int letter_slot(byte letter);
        for (int i = 0; i < NUM_AMINO; i++)
        begin
            if (amino_alpha[i] == letter) return i;
        end
        return 0;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Advance the model by one request and return the result it must produce
    function automatic cth_out_t codon_step(cth_in_t req);
        cth_out_t   r;
        logic [1:0] b;
        int         st;
        int         hit;
        byte        aa_ch;
        r   = '0;
        hit = -1;
        st  = frame_code;
        if (req.kind == KIND_READ)
        begin
            r.amino_index = req.read_index;
            if (req.read_index < NUM_AMINO)
            begin
                r.amino_letter = 7'(amino_alpha[req.read_index]);
                r.count_value  = amino_count[req.read_index];
            end
        end
        else
        begin
            b = nucleotide_code(req.base_char);
            if (st <= FR_SEEN_AT)
            begin
                // start search: an A always restarts at "A seen"
                if (b == BASE_A)
                    st = FR_SEEN_A;
                else if (st == FR_SEEN_A && b == BASE_T)
                    st = FR_SEEN_AT;
                else if (st == FR_SEEN_AT && b == BASE_G)
                begin
                    hit = int'(AA_M);
                    st  = FR_CODON;
                end
                else
                    st = FR_SEARCH;
            end
            else if (st == FR_CODON)
                st = 4 + int'(b);
            else if (st < 8)
                st = 8 + 4 * (st - 4) + int'(b);
            else
            begin
                aa_ch = codon_letters[4 * (st - 8) + int'(b)];
                if (aa_ch == "*")
                begin
                    r.stop_codon = 1'b1;
                    st = FR_SEARCH;
                end
                else
                begin
                    hit = letter_slot(aa_ch);
                    st  = FR_CODON;
                end
            end
            if (hit >= 0)
            begin
                amino_count[hit] = bump(amino_count[hit]);
                total_count      = bump(total_count);
                r.emitted        = 1'b1;
                r.amino_index    = 5'(hit);
                r.amino_letter   = 7'(amino_alpha[hit]);
                r.count_value    = amino_count[hit];
            end
            frame_code = st;
        end
        r.in_frame    = (frame_code >= FR_CODON);
        r.total_value = total_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_row(logic kind, logic [7:0] ch, logic [4:0] idx, bit fixed,
                           cth_out_t res);
        stim_row_t row;
        row.req.kind       = kind;
        row.req.base_char  = ch;
        row.req.read_index = idx;
        row.fixed          = fixed;
        row.res            = res;
        stim_q.insert(stim_q.size(), row);
    endtask

    task automatic push_read();
        add_row(KIND_READ, 8'($urandom_range(255)), 5'($urandom_range(31)), 1'b0, '0);
    endtask

    // A base request, sometimes after a random read; G is sometimes sent as some other unrecognized byte
    task automatic push_base(logic [1:0] code);
        logic [7:0] ch;
        if ($urandom_range(9) == 0) push_read();
        case (code)
            BASE_T:  ch = "T";
            BASE_C:  ch = "C";
            BASE_A:  ch = "A";
            default:
            begin
                ch = "G";
                if ($urandom_range(3) == 0)
                begin
                    ch = 8'($urandom_range(255));
                    if (ch == "T" || ch == "C" || ch == "A") ch = "G";
                end
            end
        endcase
        add_row(KIND_BASE, ch, 5'($urandom_range(31)), 1'b0, '0);
    endtask

    // Noise, ATG, random sense codons, then mostly a stop, else a cut-off frame
    task automatic queue_gene();
        logic [1:0] b1, b2, b3;
        int         n;
        repeat ($urandom_range(3))
        begin
            if ($urandom_range(2) == 0)
                push_read();
            else
                add_row(KIND_BASE, 8'($urandom_range(255)), 5'($urandom_range(31)),
                        1'b0, '0);
        end
        push_base(BASE_A);
        push_base(BASE_T);
        push_base(BASE_G);
        n = $urandom_range(10);
        repeat (n)
        begin
            do
            begin
                b1 = 2'($urandom_range(3));
                b2 = 2'($urandom_range(3));
                b3 = 2'($urandom_range(3));
            end while (codon_letters[16 * b1 + 4 * b2 + b3] == "*");
            push_base(b1);
            push_base(b2);
            push_base(b3);
        end
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 2)) push_base(2'($urandom_range(3)));
        end
        else
        begin
            push_base(BASE_T);
            case ($urandom_range(2))
                0:
                begin
                    push_base(BASE_A);
                    push_base(BASE_A);
                end
                1:
                begin
                    push_base(BASE_A);
                    push_base(BASE_G);
                end
                default:
                begin
                    push_base(BASE_G);
                    push_base(BASE_A);
                end
            endcase
        end
    endtask

    // Hold off until every queued request has gone and every result is back
    task automatic wait_drained();
        @(negedge clk);
        while (stim_q.size() != 0 || nuc_valid || translation_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Request driver, result checker
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        stim_row_t row;
        cth_out_t  want;
        if (!rst_n)
        begin
            nuc_valid <= 1'b0;
            res_ready <= 1'b0;
        end
        else
        begin
            // request accepted: predict its result
            if (nuc_valid && nuc_ready)
            begin
                want = codon_step(in_flight.req);
                translation_q.insert(translation_q.size(),
                                     in_flight.fixed ? in_flight.res : want);
            end

            // result accepted: compare with the oldest prediction
            if (res_valid && res_ready)
            begin
                if (translation_q.size() == 0)
                begin
                    $error("unexpected result: %p", res_data);
                    fail_count++;
                end
                else
                begin
                    want = translation_q.pop_front();
                    if (res_data.emitted !== want.emitted)
                    begin
                        $error("emitted: expected %0d, actual %0d",
                               want.emitted, res_data.emitted);
                        fail_count++;
                    end
                    if (res_data.amino_index !== want.amino_index)
                    begin
                        $error("amino_index: expected %0d, actual %0d",
                               want.amino_index, res_data.amino_index);
                        fail_count++;
                    end
                    if (res_data.amino_letter !== want.amino_letter)
                    begin
                        $error("amino_letter: expected %0d, actual %0d",
                               want.amino_letter, res_data.amino_letter);
                        fail_count++;
                    end
                    if (res_data.stop_codon !== want.stop_codon)
                    begin
                        $error("stop_codon: expected %0d, actual %0d",
                               want.stop_codon, res_data.stop_codon);
                        fail_count++;
                    end
                    if (res_data.in_frame !== want.in_frame)
                    begin
                        $error("in_frame: expected %0d, actual %0d",
                               want.in_frame, res_data.in_frame);
                        fail_count++;
                    end
                    if (res_data.count_value !== want.count_value)
                    begin
                        $error("count_value: expected %0d, actual %0d",
                               want.count_value, res_data.count_value);
                        fail_count++;
                    end
                    if (res_data.total_value !== want.total_value)
                    begin
                        $error("total_value: expected %0d, actual %0d",
                               want.total_value, res_data.total_value);
                        fail_count++;
                    end
                end
            end

            // next request, only once the current one is gone
            if (!nuc_valid || nuc_ready)
            begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    row = stim_q.pop_front();
                    in_flight <= row;
                    nuc_data  <= row.req;
                    nuc_valid <= 1'b1;
                end
                else
                    nuc_valid <= 1'b0;
            end

            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too many cycles with no handshake on either channel
    initial
    begin : watchdog_proc
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG)
        begin
            @(posedge clk);
            if ((nuc_valid && nuc_ready) || (res_valid && res_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_proc
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 72, 0, 29};
        recv_pct = '{0, 0, 72, 29};

        frame_code  = FR_SEARCH;
        total_count = '0;
        foreach (amino_count[i]) amino_count[i] = '0;

        // Directed: reads after reset, byte extremes, overlapping A, start,
        // sense codon, stop, out-of-range read, lowercase byte as G
        add_row(KIND_READ, 8'h00, AA_A,  1'b1, '{1'b0, AA_A, 7'h41, 1'b0, 1'b0, 32'd0, 32'd0});
        add_row(KIND_READ, 8'hFF, 5'd31, 1'b1, '{1'b0, 5'd31, 7'h00, 1'b0, 1'b0, 32'd0, 32'd0});
        add_row(KIND_READ, 8'h00, AA_Y,  1'b1, '{1'b0, AA_Y, 7'h59, 1'b0, 1'b0, 32'd0, 32'd0});
        add_row(KIND_BASE, 8'h00, 5'd31, 1'b1, '0);
        add_row(KIND_BASE, 8'hFF, 5'd0,  1'b1, '0);
        add_row(KIND_BASE, "A",   5'd0,  1'b1, '0);
        add_row(KIND_BASE, "A",   5'd0,  1'b1, '0);
        add_row(KIND_BASE, "T",   5'd0,  1'b1, '0);
        add_row(KIND_BASE, "G",   5'd0,  1'b1, '{1'b1, AA_M, 7'h4D, 1'b0, 1'b1, 32'd1, 32'd1});
        add_row(KIND_BASE, "T",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "G",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "G",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "T",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "A",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "A",   5'd0,  1'b1, '{1'b0, 5'd0, 7'h00, 1'b1, 1'b0, 32'd0, 32'd2});
        add_row(KIND_READ, 8'h00, AA_M,  1'b0, '0);
        add_row(KIND_READ, 8'h00, 5'd20, 1'b0, '0);
        add_row(KIND_BASE, "A",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "T",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, 8'h67, 5'd0,  1'b0, '0);
        add_row(KIND_BASE, "T",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "G",   5'd0,  1'b0, '0);
        add_row(KIND_BASE, "A",   5'd0,  1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Random genes under each idling pattern, draining between phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            while (stim_q.size() < PHASE_ITEMS) queue_gene();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (translation_q.size() != 0)
        begin
            $error("%0d results never arrived", translation_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- codon_translator_histogram.f -----
rtl/cth_pkg.sv
rtl/cth_ram.sv
rtl/cth_outq.sv
rtl/codon_translator_histogram.sv
bench/codon_translator_histogram_tb.sv
